[hdl/plsu_pkg.sv]
// Shared types, codes and defaults of the positional list store.
`default_nettype none

package plsu_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int ACTION_WIDTH = 2;
   localparam int POS_WIDTH    = 5;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;
   localparam int POS_MAX      = (1 << POS_WIDTH) - 1;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SET    = 2'd2,
      ACT_GET    = 2'd3
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Edit command broadcast to every cell of the chain.
   typedef struct packed {
      logic                 insert_en;
      logic                 remove_en;
      logic                 set_en;
      logic [POS_WIDTH-1:0] pos;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hdl/plsu_req_if.sv]
// Request channel: valid/ready handshake with action, position and value.
`default_nettype none

interface plsu_req_if import plsu_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [ACTION_WIDTH-1:0] action;
   logic [POS_WIDTH-1:0]    position;
   logic [VALUE_WIDTH-1:0]  value;

   modport source (output valid, output action, output position, output value, input ready);
   modport sink   (input valid, input action, input position, input value, output ready);
endinterface

`default_nettype wire

[hdl/plsu_rsp_if.sv]
// Response channel: valid/ready handshake with status, read value and count.
`default_nettype none

interface plsu_rsp_if import plsu_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [VALUE_WIDTH-1:0]  read_value;
   logic [COUNT_WIDTH-1:0]  count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

`default_nettype wire

[hdl/plsu_cell.sv]
// One storage cell of the list: holds one entry and trades it with its neighbors.
`default_nettype none

module plsu_cell import plsu_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter bit IS_LAST    = 1'b0
) (
   input  wire logic                  clock,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [DATA_WIDTH-1:0] value,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output logic      [DATA_WIDTH-1:0] data_q
);

   localparam bit                   ABOVE_POS = (INDEX > POS_MAX);
   localparam logic [POS_WIDTH-1:0] INDEX_LOW = POS_WIDTH'(INDEX);

   logic                  is_eq;
   logic                  is_gt;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   assign is_eq = !ABOVE_POS && (ctrl.pos == INDEX_LOW);
   assign is_gt = ABOVE_POS || (INDEX_LOW > ctrl.pos);

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert_en) begin
         if (is_gt) begin
            data_in = left_data;
         end else if (is_eq) begin
            data_in = value;
         end
      end else if (ctrl.remove_en) begin
         // close the gap; the last cell holds, its slot falls out of the count
         if ((is_gt || is_eq) && !IS_LAST) begin
            data_in = right_data;
         end
      end else if (ctrl.set_en && is_eq) begin
         data_in = value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

`default_nettype wire

[hdl/positional_list_store_unit.sv]
// Top level of the positional list store: request decode, cell chain and response register.
//
//   channel   dir  handshake           payload
//   req_chan  in   valid/ready         action, position, value
//   rsp_chan  out  valid/ready         status, read_value, count
//
// One item per cycle: every cell of the chain moves in the same cycle, so an
// insert or remove shifts all later entries at once. A response appears the
// cycle after its item is accepted and sits in the response register.
// While that register holds an unread response, a new item is accepted only in
// the cycle the response is taken. Reset (synchronous) empties the list and the
// response register; entry contents are not cleared.
`default_nettype none

module positional_list_store_unit import plsu_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   plsu_req_if.sink   req_chan,
   plsu_rsp_if.source rsp_chan
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   // accepted item decode
   logic                  accept;
   action_type            action;
   logic [CMP_W-1:0]      pos_cmp;
   logic [CMP_W-1:0]      cnt_cmp;
   logic [DATA_WIDTH-1:0] value_d;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_word;
   status_type            status;
   logic [VALUE_WIDTH-1:0] rd_value;
   cell_ctrl_type         ctrl;

   // control state
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // response payload
   status_type             rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

   // take a new item whenever the response register is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign action  = action_type'(req_chan.action);
   assign pos_cmp = CMP_W'(req_chan.position);
   assign cnt_cmp = CMP_W'(cnt_ff);
   assign value_d = DATA_WIDTH'(req_chan.value);
   assign rd_addr = ADDR_W'(req_chan.position);
   assign rd_word = cell_q[rd_addr];

   // decide status, cell command and next count
   always_comb begin
      status         = ST_OK;
      rd_value       = '0;
      cnt_in         = cnt_ff;
      ctrl.insert_en = 1'b0;
      ctrl.remove_en = 1'b0;
      ctrl.set_en    = 1'b0;
      ctrl.pos       = req_chan.position;
      case (action)
         ACT_INSERT: begin
            if (pos_cmp > cnt_cmp) begin
               status = ST_BAD_POS;
            end else if (cnt_ff == CNT_FULL) begin
               status = ST_FULL;
            end else begin
               ctrl.insert_en = accept;
               if (accept) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ACT_REMOVE: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_BAD_POS;
            end else begin
               ctrl.remove_en = accept;
               if (accept) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         ACT_SET: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_BAD_POS;
            end else begin
               ctrl.set_en = accept;
            end
         end
         ACT_GET: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_BAD_POS;
            end else begin
               rd_value = VALUE_WIDTH'(rd_word);
            end
         end
         default: begin
            status = ST_BAD_POS;
         end
      endcase
   end

   // hold the response until taken, load a fresh one on each accepted item
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= rd_value;
         rsp_count_ff  <= COUNT_WIDTH'(cnt_in);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.count      = rsp_count_ff;

   // the chain: cell i holds entry i, takes from i-1 on insert, from i+1 on remove
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = cell_q[0];
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_q[CAPACITY-1];
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end

      plsu_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .IS_LAST    (i == CAPACITY - 1)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .value      (value_d),
         .left_data  (left_d),
         .right_data (right_d),
         .data_q     (cell_q[i])
      );
   end

endmodule

`default_nettype wire

[hdl/plsu_checker.sv]
// Port-level checks of the positional list store, bound to the top level.
`default_nettype none

module plsu_checker import plsu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [STATUS_WIDTH-1:0] rsp_status,
   input wire logic [VALUE_WIDTH-1:0]  rsp_read_value,
   input wire logic [COUNT_WIDTH-1:0]  rsp_count
);

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled response changed");

   // every accepted item yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no response");

   // a failed request reads nothing
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("nonzero read value on failed request");

   // full status only when the store is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_COUNT)
      else $error("full status below capacity");

endmodule

bind positional_list_store_unit plsu_checker #(.CAPACITY(CAPACITY)) u_plsu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_count      (rsp_chan.count)
);

`default_nettype wire

[test/plsu_list_shadow.sv]
// Shadow model and in-order response checker for the positional list store.
module plsu_list_shadow import plsu_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   plsu_req_if        req_mon,
   plsu_rsp_if        rsp_mon,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      status_type               status;
      logic [VALUE_WIDTH-1:0]   read_value;
      logic [COUNT_WIDTH-1:0]   count;
   } list_outcome;

   localparam logic [VALUE_WIDTH-1:0] DATA_MASK = VALUE_WIDTH'((64'd1 << DATA_WIDTH) - 64'd1);

   logic [VALUE_WIDTH-1:0] stored_words [CAPACITY];
   int                     word_count = 0;
   list_outcome            awaited_outcomes [$];
   int                     mismatches = 0;
   int                     outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   // Apply one edit to the shadow list and return the response it must produce.
   function automatic list_outcome apply_edit(action_type act,
                                              logic [POS_WIDTH-1:0] pos,
                                              logic [VALUE_WIDTH-1:0] word);
      list_outcome res;
      int          at;
      at             = int'(pos);
      res.status     = ST_OK;
      res.read_value = '0;
      if (act == ACT_INSERT) begin
         if (at > word_count) begin
            res.status = ST_BAD_POS;
         end else if (word_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            for (int i = word_count; i > at; i--) stored_words[i] = stored_words[i-1];
            stored_words[at] = word & DATA_MASK;
            word_count++;
         end
      end else if (at >= word_count) begin
         res.status = ST_BAD_POS;
      end else begin
         case (act)
            ACT_REMOVE: begin
               for (int i = at; i + 1 < word_count; i++) stored_words[i] = stored_words[i+1];
               word_count--;
            end
            ACT_SET: begin
               stored_words[at] = word & DATA_MASK;
            end
            default: begin
               res.read_value = stored_words[at];
            end
         endcase
      end
      res.count = COUNT_WIDTH'(word_count);
      return res;
   endfunction

   task automatic note_mismatch(string field, logic [VALUE_WIDTH-1:0] want,
                                logic [VALUE_WIDTH-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : watch
      list_outcome want;
      if (reset) begin
         awaited_outcomes.delete();
         word_count = 0;
      end else begin
         // Retire the response first: it always belongs to an earlier item.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: response with nothing expected, actual status %0h value %0h count %0h",
                        $time, rsp_mon.status, rsp_mon.read_value, rsp_mon.count);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_mon.status !== want.status)
                  note_mismatch("status", VALUE_WIDTH'(want.status), VALUE_WIDTH'(rsp_mon.status));
               if (rsp_mon.read_value !== want.read_value)
                  note_mismatch("read_value", want.read_value, rsp_mon.read_value);
               if (rsp_mon.count !== want.count)
                  note_mismatch("count", VALUE_WIDTH'(want.count), VALUE_WIDTH'(rsp_mon.count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_outcomes.push_back(apply_edit(action_type'(req_mon.action),
                                                  req_mon.position, req_mon.value));
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

[test/tb_positional_list_store_unit.sv]
// Top of the positional list store testbench: clock, reset, stimulus, pacing and verdict.
module tb_positional_list_store_unit;
   import plsu_pkg::*;

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_SLOW,
      PACE_RECEIVER_SLOW,
      PACE_BOTH_SLOW
   } pace_type;

   localparam int CAPACITY         = CAPACITY_DEF;
   localparam int ITEMS_PER_PHASE  = 470;
   localparam int SETTLE_CYCLES    = 8;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_fire = 1'b0;
   pace_type pace = PACE_STEADY;
   int       list_len = 0;     // stimulus-side length, used to aim positions, pick actions and end the fill
   int       fail_count;
   int       pending_count;

   plsu_req_if req_chan ();
   plsu_rsp_if rsp_chan ();

   positional_list_store_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   plsu_list_shadow u_list_shadow (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Record each request handshake so the driver can see it at the next falling edge.
   always @(posedge clock) req_fire <= req_chan.valid && req_chan.ready;

   // Response side: stall at random according to the current pace.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         case (pace)
            PACE_RECEIVER_SLOW: rsp_chan.ready <= ($urandom_range(99) >= 87);
            PACE_BOTH_SLOW:     rsp_chan.ready <= ($urandom_range(99) >= 21);
            default:            rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   // Present one item; enter and leave at a falling edge. Hold the item until it
   // is taken, and track the list length so random positions stay mostly in range.
   task automatic issue_edit(input action_type act, input int unsigned pos,
                             input logic [VALUE_WIDTH-1:0] word);
      int unsigned gap_pct;
      case (pace)
         PACE_SENDER_SLOW: gap_pct = 87;
         PACE_BOTH_SLOW:   gap_pct = 21;
         default:          gap_pct = 0;
      endcase
      if ($urandom_range(99) < gap_pct) begin
         // Idle with junk on the payload lines.
         req_chan.valid    <= 1'b0;
         req_chan.action   <= ACTION_WIDTH'($urandom);
         req_chan.position <= POS_WIDTH'($urandom);
         req_chan.value    <= $urandom;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.position <= POS_WIDTH'(pos);
      req_chan.value    <= word;
      do @(negedge clock); while (!req_fire);
      if (act == ACT_INSERT && pos <= list_len && list_len < CAPACITY)
         list_len++;
      else if (act == ACT_REMOVE && pos < list_len)
         list_len--;
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.action   = ACT_GET;
      req_chan.position = '0;
      req_chan.value    = '0;

      // Hold reset at the start, release it at a falling edge.
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, every action out of range.
      issue_edit(ACT_GET,    0, 32'h0);
      issue_edit(ACT_REMOVE, 0, 32'h0);
      issue_edit(ACT_SET,    0, 32'hDEAD_BEEF);
      issue_edit(ACT_INSERT, 1, 32'h1111_1111);     // just past the count
      issue_edit(ACT_INSERT, POS_MAX, 32'h2222_2222);
      // Build a short list: append, front and middle inserts, value extremes.
      issue_edit(ACT_INSERT, 0, 32'h0000_0000);
      issue_edit(ACT_INSERT, 1, 32'hFFFF_FFFF);
      issue_edit(ACT_INSERT, 0, 32'hA5A5_5A5A);
      issue_edit(ACT_INSERT, 1, 32'h1234_5678);
      issue_edit(ACT_GET,    0, 32'h0);
      issue_edit(ACT_GET,    3, 32'h0);
      issue_edit(ACT_SET,    3, 32'h8000_0001);
      issue_edit(ACT_GET,    3, 32'hFFFF_FFFF);     // value ignored on get
      issue_edit(ACT_REMOVE, 1, 32'h0);
      issue_edit(ACT_GET,    3, 32'h0);             // position equal to count
      // Fill to capacity, then push on the full list.
      while (list_len < CAPACITY)
         issue_edit(ACT_INSERT, $urandom_range(list_len, 0), $urandom);
      issue_edit(ACT_INSERT, CAPACITY, 32'h5555_5555);
      issue_edit(ACT_INSERT, 0, 32'hAAAA_AAAA);
      issue_edit(ACT_INSERT, CAPACITY + 1, 32'h0);  // position check wins over full
      issue_edit(ACT_GET,    CAPACITY - 1, 32'h0);
      issue_edit(ACT_GET,    CAPACITY, 32'h0);
      issue_edit(ACT_REMOVE, CAPACITY - 1, 32'h0);
      issue_edit(ACT_REMOVE, 0, 32'h0);

      // Random: one phase per pace. Mostly in-range positions, some noise.
      for (int p = 0; p < 4; p++) begin
         pace = pace_type'(p);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin : random_item
            int unsigned roll;
            int unsigned ins_pct;
            action_type  act;
            int unsigned pos;
            logic [VALUE_WIDTH-1:0] word;
            // Lean toward growth when short so the length wanders over its range.
            ins_pct = (list_len < 2) ? 50 : (list_len >= CAPACITY) ? 20 : 32;
            roll    = $urandom_range(99);
            if (roll < ins_pct)
               act = ACT_INSERT;
            else if (roll < ins_pct + 30)
               act = ACT_REMOVE;
            else if (roll < ins_pct + 30 + (100 - ins_pct - 30) / 2)
               act = ACT_SET;
            else
               act = ACT_GET;
            if ($urandom_range(99) < 12)
               pos = $urandom_range(POS_MAX, 0);
            else if (act == ACT_INSERT)
               pos = $urandom_range(list_len, 0);
            else
               pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1, 0);
            roll = $urandom_range(99);
            if (roll < 10)
               word = '1;
            else if (roll < 15)
               word = '0;
            else
               word = $urandom;
            issue_edit(act, pos, word);
         end
      end

      // Drain, then leave room for any stray response.
      req_chan.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_positional_list_store_unit: PASS");
      else
         $display("tb_positional_list_store_unit: FAIL");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("tb_positional_list_store_unit: FAIL");
      $finish;
   end

endmodule
